@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the quadratic root solver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The implication must hold at every clock edge outside reset.
`define QRS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// The implication must hold at the next clock edge after the condition.
`define QRS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Status codes shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int STATUS_WIDTH = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_ROOTS   = 2'd0,
        STATUS_NO_REAL = 2'd1,
        STATUS_A_ZERO  = 2'd2,
        STATUS_RSVD    = 2'd3
    } status_t;

endpackage

@@ rtl/qrs_stream_if.sv @@
// ----------------------------------------------------------------------------
// qrs_stream_if
// Valid/ready channel carrying a parameterized payload.
// ----------------------------------------------------------------------------
interface qrs_stream_if #(
    parameter int PAYLOAD_WIDTH = 96
);
    logic                     valid;
    logic                     ready;
    logic [PAYLOAD_WIDTH-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/qrs_divider.sv @@
// ----------------------------------------------------------------------------
// qrs_divider
// Pipelined restoring divider, one quotient bit per stage, with a stall enable.
// ----------------------------------------------------------------------------
module qrs_divider #(
    parameter int NUM_WIDTH = 64,
    parameter int DEN_WIDTH = 64,
    parameter int TAG_WIDTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enable,
    input  logic                 in_valid,
    input  logic [NUM_WIDTH-1:0] num,
    input  logic [DEN_WIDTH-1:0] den,
    input  logic [TAG_WIDTH-1:0] tag_in,
    output logic                 out_valid,
    output logic [NUM_WIDTH-1:0] quo,
    output logic [TAG_WIDTH-1:0] tag_out
);
    localparam int REM_WIDTH = DEN_WIDTH + 1;

    logic [NUM_WIDTH-1:0] num_reg [NUM_WIDTH+1];
    logic [REM_WIDTH-1:0] rem_reg [NUM_WIDTH+1];
    logic [DEN_WIDTH-1:0] den_reg [NUM_WIDTH+1];
    logic [TAG_WIDTH-1:0] tag_reg [NUM_WIDTH+1];
    logic [NUM_WIDTH:0]   vld_reg;

    // Stage zero captures the operands.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            num_reg[0] <= num;
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            tag_reg[0] <= tag_in;
        end
    end

    // Each stage shifts in one numerator bit and settles one quotient bit.
    for (genvar s = 0; s < NUM_WIDTH; s++)
    begin : g_stage
        logic [REM_WIDTH:0]   trial;
        logic [REM_WIDTH-1:0] shifted;

        always_comb
        begin
            shifted = {rem_reg[s][REM_WIDTH-2:0], num_reg[s][NUM_WIDTH-1]};
            trial   = {1'b0, shifted} - {2'b00, den_reg[s]};
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
                if (!trial[REM_WIDTH])
                begin
                    rem_reg[s+1] <= trial[REM_WIDTH-1:0];
                    num_reg[s+1] <= {num_reg[s][NUM_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= shifted;
                    num_reg[s+1] <= {num_reg[s][NUM_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (enable)
        begin
            vld_reg <= {vld_reg[NUM_WIDTH-1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NUM_WIDTH];
    assign quo       = num_reg[NUM_WIDTH];
    assign tag_out   = tag_reg[NUM_WIDTH];
endmodule

@@ rtl/qrs_isqrt.sv @@
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, one result bit per stage, with a stall enable.
// ----------------------------------------------------------------------------
module qrs_isqrt #(
    parameter int RAD_WIDTH = 128,
    parameter int TAG_WIDTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   enable,
    input  logic                   in_valid,
    input  logic [RAD_WIDTH-1:0]   radicand,
    input  logic [TAG_WIDTH-1:0]   tag_in,
    output logic                   out_valid,
    output logic [RAD_WIDTH/2-1:0] root,
    output logic [TAG_WIDTH-1:0]   tag_out
);
    localparam int RW = RAD_WIDTH / 2;

    logic [RAD_WIDTH-1:0] rad_reg [RW+1];
    logic [RW+1:0]        rem_reg [RW+1];
    logic [RW-1:0]        res_reg [RW+1];
    logic [TAG_WIDTH-1:0] tag_reg [RW+1];
    logic [RW:0]          vld_reg;

    // Stage zero captures the radicand.
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            rad_reg[0] <= radicand;
            rem_reg[0] <= '0;
            res_reg[0] <= '0;
            tag_reg[0] <= tag_in;
        end
    end

    // Digit-by-digit method: two radicand bits in, one root bit out per stage.
    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic [RW+1:0] shifted;
        logic [RW+2:0] trial;

        always_comb
        begin
            shifted = {rem_reg[s][RW-1:0], rad_reg[s][RAD_WIDTH-1 -: 2]};
            trial   = {1'b0, shifted} - {1'b0, res_reg[s], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                rad_reg[s+1] <= {rad_reg[s][RAD_WIDTH-3:0], 2'b00};
                tag_reg[s+1] <= tag_reg[s];
                if (!trial[RW+2])
                begin
                    rem_reg[s+1] <= trial[RW+1:0];
                    res_reg[s+1] <= {res_reg[s][RW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= shifted;
                    res_reg[s+1] <= {res_reg[s][RW-2:0], 1'b0};
                end
            end
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (enable)
        begin
            vld_reg <= {vld_reg[RW-1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[RW];
    assign root      = res_reg[RW];
    assign tag_out   = tag_reg[RW];
endmodule

@@ rtl/quadratic_root_solver_unit.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// Stable quadratic formula solver on signed fixed-point coefficients.
//
//   channel  | direction | payload
//   coef_in  | sink      | {coef_c, coef_b, coef_a}
//   root_out | source    | {saturated, status, root_high, root_low}
//
// One item enters per cycle when the output side is not stalled.
// The path from an input transfer to its result transfer runs through the
// bit-serial square root and divider pipelines, which run in series.
// Any stall at the output freezes the whole pipeline; the output register
// keeps a transfer pending, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline needs no warm-up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    qrs_stream_if.sink   coef_in,
    qrs_stream_if.source root_out
);
    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int NUM = DW + 1 + FRAC_BITS + 1;
    localparam int DEN = DW + 1;
    // tag: status(2) sat-forced-zero flag(1) nega(1) negb(1) negc(1) zero-D(1) mb mc ma
    localparam int TAGW = 3 * DW + 7;

    logic enable;
    logic out_full_reg;

    assign enable        = !out_full_reg || root_out.ready;
    assign coef_in.ready = enable;

    // Stage 1: magnitudes and products.
    logic [DW-1:0] a_raw, b_raw, c_raw;
    assign a_raw = coef_in.payload[DW-1:0];
    assign b_raw = coef_in.payload[2*DW-1:DW];
    assign c_raw = coef_in.payload[3*DW-1:2*DW];

    logic          v1_reg;
    logic [DW-1:0] ma1_reg, mb1_reg, mc1_reg;
    logic          na1_reg, nb1_reg, nc1_reg;
    logic [PW-1:0] bb1_reg, ac1_reg;

    logic [DW-1:0] ma_w, mb_w, mc_w;
    assign ma_w = a_raw[DW-1] ? DW'(-a_raw) : a_raw;
    assign mb_w = b_raw[DW-1] ? DW'(-b_raw) : b_raw;
    assign mc_w = c_raw[DW-1] ? DW'(-c_raw) : c_raw;

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            ma1_reg <= ma_w;
            mb1_reg <= mb_w;
            mc1_reg <= mc_w;
            na1_reg <= a_raw[DW-1];
            nb1_reg <= b_raw[DW-1];
            nc1_reg <= c_raw[DW-1];
            bb1_reg <= mb_w * mb_w;
            ac1_reg <= ma_w * mc_w;
        end
    end

    // Stage 2: discriminant and status.
    logic            v2_reg;
    logic [PW+2:0]   d2_reg;
    logic [TAGW-1:0] tag2_reg;
    logic [PW+2:0]   bbx, acx, dsum;
    status_t         st_w;

    assign bbx  = {3'b000, bb1_reg};
    assign acx  = {1'b0, ac1_reg, 2'b00};
    assign dsum = (na1_reg != nc1_reg) ? (bbx + acx) : (bbx - acx);

    always_comb
    begin
        if (ma1_reg == '0)
            st_w = STATUS_A_ZERO;
        else if ((na1_reg == nc1_reg) && (bbx < acx))
            st_w = STATUS_NO_REAL;
        else
            st_w = STATUS_ROOTS;
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            d2_reg   <= (st_w == STATUS_ROOTS) ? dsum : '0;
            tag2_reg <= {st_w, 1'b0, na1_reg, nb1_reg, nc1_reg,
                         (st_w == STATUS_ROOTS) && (dsum == '0),
                         mb1_reg, mc1_reg, ma1_reg};
        end
    end

    // Square root of the discriminant.
    localparam int RADW = 2 * (DW + 2);
    logic                 v3;
    logic [RADW/2-1:0]    root3;
    logic [TAGW-1:0]      tag3;

    qrs_isqrt #(.RAD_WIDTH(RADW), .TAG_WIDTH(TAGW)) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable),
        .in_valid  (v2_reg),
        .radicand  (RADW'(d2_reg)),
        .tag_in    (tag2_reg),
        .out_valid (v3),
        .root      (root3),
        .tag_out   (tag3)
    );

    // Stage 4: form q and the two dividends.
    logic [DW-1:0] ma3, mb3, mc3;
    logic          na3, nb3, nc3, dz3;
    assign ma3 = tag3[DW-1:0];
    assign mc3 = tag3[2*DW-1:DW];
    assign mb3 = tag3[3*DW-1:2*DW];
    assign dz3 = tag3[3*DW];
    assign nc3 = tag3[3*DW+1];
    assign nb3 = tag3[3*DW+2];
    assign na3 = tag3[3*DW+3];

    logic [DW:0]   qmag_w;
    logic          qneg_w;
    assign qmag_w = {1'b0, mb3} + (dz3 ? '0 : (DW+1)'(root3));
    assign qneg_w = dz3 ? 1'b0 : (!nb3 && (mb3 != '0));

    logic            v4_reg;
    logic [NUM-1:0]  n0_reg, n1_reg;
    logic [DEN-1:0]  d0_reg, d1_reg;
    logic            s0_reg, s1_reg;
    logic [TAGW-1:0] tag4_reg;

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            n0_reg   <= NUM'(qmag_w) << FRAC_BITS;
            d0_reg   <= {ma3, 1'b0};
            s0_reg   <= dz3 ? ((!nb3) != na3) : (qneg_w != na3);
            n1_reg   <= NUM'(mc3) << (FRAC_BITS + 1);
            d1_reg   <= (qmag_w == '0) ? DEN'(1) : qmag_w;
            s1_reg   <= nc3 != qneg_w;
            tag4_reg <= tag3;
        end
    end

    // Two divider pipelines in parallel.
    logic           v5a, v5b;
    logic [NUM-1:0] q0, q1;
    logic [TAGW+1:0] tag5a;
    logic [0:0]     tag5b;

    qrs_divider #(.NUM_WIDTH(NUM), .DEN_WIDTH(DEN), .TAG_WIDTH(TAGW + 2)) u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable),
        .in_valid  (v4_reg),
        .num       (n0_reg),
        .den       (d0_reg),
        .tag_in    ({s1_reg, s0_reg, tag4_reg}),
        .out_valid (v5a),
        .quo       (q0),
        .tag_out   (tag5a)
    );

    qrs_divider #(.NUM_WIDTH(NUM), .DEN_WIDTH(DEN), .TAG_WIDTH(1)) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable),
        .in_valid  (v4_reg),
        .num       (n1_reg),
        .den       (d1_reg),
        .tag_in    (1'b0),
        .out_valid (v5b),
        .quo       (q1),
        .tag_out   (tag5b)
    );

    // Stage 6: clamp, sign, select and order.
    logic          s0_5, s1_5, dz5, sat0, sat1;
    logic [DW-1:0] r0, r1, lim0, lim1, m0, m1, lo_w, hi_w;
    status_t       st5;

    assign s0_5 = tag5a[TAGW];
    assign s1_5 = tag5a[TAGW+1];
    assign dz5  = tag5a[3*DW];
    assign st5  = status_t'(tag5a[TAGW-1 -: 2]);

    assign lim0 = s0_5 ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign lim1 = s1_5 ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    assign sat0 = q0 > NUM'(lim0);
    assign sat1 = !dz5 && (q1 > NUM'(lim1));
    assign m0   = sat0 ? lim0 : q0[DW-1:0];
    assign m1   = sat1 ? lim1 : q1[DW-1:0];
    assign r0   = s0_5 ? DW'(-m0) : m0;
    assign r1   = dz5 ? r0 : (s1_5 ? DW'(-m1) : m1);

    always_comb
    begin
        if ($signed(r0) > $signed(r1))
        begin
            lo_w = r1;
            hi_w = r0;
        end
        else
        begin
            lo_w = r0;
            hi_w = r1;
        end
    end

    logic [DW-1:0] lo_reg, hi_reg;
    status_t       st_reg;
    logic          sat_reg;

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            if (st5 == STATUS_ROOTS)
            begin
                lo_reg  <= lo_w;
                hi_reg  <= hi_w;
                sat_reg <= sat0 || sat1;
            end
            else
            begin
                lo_reg  <= '0;
                hi_reg  <= '0;
                sat_reg <= 1'b0;
            end
            st_reg <= st5;
        end
    end

    // Control valid bits of the short stages and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg       <= coef_in.valid;
            v2_reg       <= v1_reg;
            v4_reg       <= v3;
            out_full_reg <= v5a;
        end
    end

    assign root_out.valid   = out_full_reg;
    assign root_out.payload = {sat_reg, st_reg, hi_reg, lo_reg};

    `QRS_ASSERT_IMPLY(a_div_align, clk, rst_n, 1'b1, v5a == v5b)
    `QRS_ASSERT_IMPLY(a_no_real_zero, clk, rst_n,
        root_out.valid && (st_reg != STATUS_ROOTS),
        (lo_reg == '0) && (hi_reg == '0) && !sat_reg)
    `QRS_ASSERT_IMPLY(a_ordered, clk, rst_n, root_out.valid && (st_reg == STATUS_ROOTS),
        $signed(lo_reg) <= $signed(hi_reg))
    `QRS_ASSERT_NEXT(a_hold, clk, rst_n, root_out.valid && !root_out.ready,
        root_out.valid && $stable(root_out.payload))
endmodule

@@ tb/quadratic_root_solver_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit_tb
// Streams quadratic coefficient sets through the solver and checks each root
// pair, status and saturation flag against a predictor of the fixed-point
// quadratic formula. Both channels idle at random, and the root side holds
// off once for a long stretch so that the pipeline fills and stalls.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit_tb;
    import qrs_pkg::*;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_WIDTH = 3 * DATA_WIDTH;
    localparam int ROOT_WIDTH = 2 * DATA_WIDTH + STATUS_WIDTH + 1;
    localparam int RANDOM_ITEMS = 1630;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        logic                  sat;
        status_t               status;
        logic [DATA_WIDTH-1:0] hi;
        logic [DATA_WIDTH-1:0] lo;
    } roots_t;

    logic clk;
    logic rst_n;

    qrs_stream_if #(.PAYLOAD_WIDTH(COEF_WIDTH)) coef_in ();
    qrs_stream_if #(.PAYLOAD_WIDTH(ROOT_WIDTH)) root_out ();

    logic [COEF_WIDTH-1:0] coef_queue[$];
    roots_t                roots_expected[$];
    int                    coef_count;
    int                    root_count;
    int                    cycle_count = 0;
    int                    coef_wait;
    int                    root_wait;
    int                    hold_left;
    logic                  hold_done;
    logic                  failed = 1'b0;

    quadratic_root_solver_unit #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .coef_in (coef_in.sink),
        .root_out(root_out.source)
    );

    // Divide magnitudes, apply the sign and clamp to the signed range.
    function automatic logic [DATA_WIDTH-1:0] clamped_quotient(
        input logic [127:0] num,
        input logic [127:0] den,
        input logic         neg,
        inout logic         sat
    );
        logic [127:0]          q;
        logic [127:0]          lim;
        logic [DATA_WIDTH-1:0] m;
        q   = num / den;
        lim = neg ? (128'd1 << (DATA_WIDTH - 1)) : ((128'd1 << (DATA_WIDTH - 1)) - 1);
        if (q > lim)
        begin
            q   = lim;
            sat = 1'b1;
        end
        m = q[DATA_WIDTH-1:0];
        return neg ? -m : m;
    endfunction

    // Roots of a*x^2 + b*x + c in the cancellation-free form.
    function automatic roots_t solve_quadratic(input logic [COEF_WIDTH-1:0] coefs);
        logic [DATA_WIDTH-1:0] a, b, c, ma, mb, mc, r0, r1, t;
        logic                  na, nb, nc, qneg, sat;
        logic [127:0]          bb, ac, disc, qmag, den;
        logic [63:0]           root, cand;
        roots_t                res;
        a   = coefs[DATA_WIDTH-1:0];
        b   = coefs[2*DATA_WIDTH-1:DATA_WIDTH];
        c   = coefs[3*DATA_WIDTH-1:2*DATA_WIDTH];
        na  = a[DATA_WIDTH-1];
        nb  = b[DATA_WIDTH-1];
        nc  = c[DATA_WIDTH-1];
        ma  = na ? -a : a;
        mb  = nb ? -b : b;
        mc  = nc ? -c : c;
        sat = 1'b0;
        res = '{hi: '0, lo: '0, status: STATUS_ROOTS, sat: 1'b0};
        if (ma == 0)
        begin
            res.status = STATUS_A_ZERO;
            return res;
        end
        bb = 128'(mb) * 128'(mb);
        ac = (128'(ma) * 128'(mc)) << 2;
        if (na != nc)
            disc = bb + ac;
        else if (bb < ac)
        begin
            res.status = STATUS_NO_REAL;
            return res;
        end
        else
            disc = bb - ac;
        den = 128'(ma) << 1;
        if (disc == 0)
        begin
            r0 = clamped_quotient(128'(mb) << FRAC_BITS, den, (!nb) != na, sat);
            r1 = r0;
        end
        else
        begin
            // Integer square root, rounded down.
            root = '0;
            for (int i = 63; i >= 0; i--)
            begin
                cand = root | (64'd1 << i);
                if (128'(cand) * 128'(cand) <= disc)
                    root = cand;
            end
            qmag = 128'(mb) + 128'(root);
            qneg = !nb && (mb != 0);
            r0 = clamped_quotient(qmag << FRAC_BITS, den, qneg != na, sat);
            r1 = clamped_quotient(128'(mc) << (FRAC_BITS + 1), qmag, nc != qneg, sat);
        end
        if ($signed(r0) > $signed(r1))
        begin
            t  = r0;
            r0 = r1;
            r1 = t;
        end
        res.lo  = r0;
        res.hi  = r1;
        res.sat = sat;
        return res;
    endfunction

    function automatic logic [COEF_WIDTH-1:0] pack_coefs(
        input logic [DATA_WIDTH-1:0] a,
        input logic [DATA_WIDTH-1:0] b,
        input logic [DATA_WIDTH-1:0] c
    );
        return {c, b, a};
    endfunction

    // Idle draw; every few hundred transfers a stretch runs without gaps.
    function automatic int idle_draw(input int count);
        return ((count % 400) < 100) ? 0 : int'($urandom_range(0, 3));
    endfunction

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Coefficient driver: holds each item until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_in.valid   <= 1'b0;
            coef_in.payload <= '0;
            coef_wait       <= 0;
            coef_count      <= 0;
        end
        else if (!(coef_in.valid && !coef_in.ready))
        begin
            if (coef_in.valid)
            begin
                roots_expected.push_back(solve_quadratic(coef_in.payload));
                coef_count <= coef_count + 1;
            end
            if (coef_wait != 0)
            begin
                coef_wait     <= coef_wait - 1;
                coef_in.valid <= 1'b0;
            end
            else if (coef_queue.size() != 0)
            begin
                coef_in.payload <= coef_queue.pop_front();
                coef_in.valid   <= 1'b1;
                coef_wait       <= idle_draw(coef_count);
            end
            else
                coef_in.valid <= 1'b0;
        end
    end

    // Long hold-off of the root side, counted in cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && root_count >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Root monitor: checks each transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        roots_t got;
        roots_t want;
        int     w;
        if (!rst_n)
        begin
            root_out.ready <= 1'b0;
            root_wait      <= 0;
            root_count     <= 0;
        end
        else
        begin
            w = (root_wait != 0) ? root_wait - 1 : 0;
            if (root_out.valid && root_out.ready)
            begin
                got = root_out.payload;
                root_count <= root_count + 1;
                if (roots_expected.size() == 0)
                begin
                    $error("unexpected root transfer %h", root_out.payload);
                    failed = 1'b1;
                end
                else
                begin
                    want = roots_expected.pop_front();
                    if (got.lo !== want.lo)
                    begin
                        $error("root_low: expected %h, got %h", want.lo, got.lo);
                        failed = 1'b1;
                    end
                    if (got.hi !== want.hi)
                    begin
                        $error("root_high: expected %h, got %h", want.hi, got.hi);
                        failed = 1'b1;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failed = 1'b1;
                    end
                    if (got.sat !== want.sat)
                    begin
                        $error("saturated: expected %b, got %b", want.sat, got.sat);
                        failed = 1'b1;
                    end
                end
                w = idle_draw(root_count);
            end
            root_wait      <= w;
            root_out.ready <= (w == 0) && (hold_left == 0);
        end
    end

    // Run time limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** quadratic_root_solver_unit: FAILED **");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [DATA_WIDTH-1:0] a, b, c;
        logic signed [63:0]    ra, r1, r2;
        logic [31:0]           edges [4];
        int                    sel;
        rst_n       = 1'b0;
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};

        // Directed: zero leading coefficient, no real roots, double root,
        // zero linear coefficient, saturation and the field extremes.
        coef_queue.push_back(pack_coefs(32'h0, 32'h1234_5678, 32'h8000_0000));
        coef_queue.push_back(pack_coefs(32'h0, 32'h0, 32'h0));
        coef_queue.push_back(pack_coefs(32'h0001_0000, 32'h0, 32'h0001_0000));
        coef_queue.push_back(pack_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000));
        coef_queue.push_back(pack_coefs(32'hffff_0000, 32'h0004_0000, 32'hfffc_0000));
        coef_queue.push_back(pack_coefs(32'h0001_0000, 32'h0, 32'hfffc_0000));
        coef_queue.push_back(pack_coefs(32'hffff_0000, 32'h0, 32'h0009_0000));
        coef_queue.push_back(pack_coefs(32'h0001_0000, 32'h0, 32'h0));
        coef_queue.push_back(pack_coefs(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001));
        coef_queue.push_back(pack_coefs(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        for (int i = 0; i < 12; i++)
            coef_queue.push_back(pack_coefs(edges[i % 2], edges[(i / 2) % 4],
                                            edges[(i / 3) % 4]));
        coef_queue.push_back(pack_coefs(32'h0000_0001, 32'h0, 32'h0000_0001));

        // Random: mostly built from chosen roots, the rest raw bit patterns.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                ra = $signed(64'($urandom_range(1, 32'h0004_0000)));
                if ($urandom_range(0, 1)) ra = -ra;
                r1 = $signed(64'($urandom_range(0, 32'h0010_0000))) - 64'sh0008_0000;
                r2 = ($urandom_range(0, 3) == 0) ? r1 :
                     $signed(64'($urandom_range(0, 32'h0010_0000))) - 64'sh0008_0000;
                a = ra[31:0];
                b = 32'((-(ra * (r1 + r2))) >>> FRAC_BITS);
                c = 32'((((ra * r1) >>> FRAC_BITS) * r2) >>> FRAC_BITS);
            end
            else if (sel < 9)
            begin
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
                c = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1)) a = -a;
                if ($urandom_range(0, 1)) b = -b;
                if ($urandom_range(0, 1)) c = -c;
            end
            else
            begin
                a = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
                b = $urandom;
                c = $urandom;
            end
            coef_queue.push_back(pack_coefs(a, b, c));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (coef_queue.size() == 0 && !coef_in.valid);
        wait (roots_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (roots_expected.size() != 0)
            $error("%0d root sets never arrived", roots_expected.size());
        if (!failed && (roots_expected.size() == 0))
            $display("** quadratic_root_solver_unit: PASSED **");
        else
            $display("** quadratic_root_solver_unit: FAILED **");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_stream_if.sv
rtl/qrs_divider.sv
rtl/qrs_isqrt.sv
rtl/quadratic_root_solver_unit.sv
tb/quadratic_root_solver_unit_tb.sv
